@@ rtl/core/lrast_pkg.sv @@
// Shared constants, configuration type and color conversion for the line rasterizer.
`timescale 1ns / 1ps

package lrast_pkg;

   // Default coordinate width and the fixed field widths of the block.
   localparam int COORD_BITS_DEF = 11;
   localparam int FB_DIM_BITS    = 12;
   localparam int OFFSET_BITS    = 22;
   localparam int COLOR_BITS     = 32;
   localparam int MODE_BITS      = 2;

   // Command queue between the setup front end and the walker.
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

   // Configuration register port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_WIDTH        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_HEIGHT       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_MODE      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROTATE_QUARTER  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLIP_HORIZONTAL = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLIP_VERTICAL   = 3'd5;

   // Request kinds.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // Color modes.
   localparam logic [MODE_BITS-1:0] MODE_PASS     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ARGB1555 = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_XGRB32   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [FB_DIM_BITS-1:0] FB_WIDTH_RESET  = 12'd640;
   localparam logic [FB_DIM_BITS-1:0] FB_HEIGHT_RESET = 12'd480;

   // Channel masks used by the color conversion.
   localparam logic [COLOR_BITS-1:0] MASK_BLUE5  = 32'h0000_00F8;
   localparam logic [COLOR_BITS-1:0] MASK_GREEN5 = 32'h0000_F800;
   localparam logic [COLOR_BITS-1:0] MASK_RED5   = 32'h00F8_0000;
   localparam logic [COLOR_BITS-1:0] MASK_ALPHA1 = 32'h8000_0000;
   localparam logic [COLOR_BITS-1:0] MASK_BYTE0  = 32'h0000_00FF;
   localparam logic [COLOR_BITS-1:0] MASK_BYTE1  = 32'h0000_FF00;
   localparam logic [COLOR_BITS-1:0] MASK_BYTE2  = 32'h00FF_0000;

   typedef struct packed {
      logic [FB_DIM_BITS-1:0] fb_width;
      logic [FB_DIM_BITS-1:0] fb_height;
      logic [MODE_BITS-1:0]   color_mode;
      logic                   rotate_quarter;
      logic                   flip_horizontal;
      logic                   flip_vertical;
   } cfg_type;

   function automatic logic [COLOR_BITS-1:0] convert_color(
      input logic [MODE_BITS-1:0]  mode,
      input logic [COLOR_BITS-1:0] c
   );
      logic [COLOR_BITS-1:0] result;
      unique case (mode)
         MODE_ARGB1555: begin
            result = ((c & MASK_BLUE5) >> 3) | ((c & MASK_GREEN5) >> 6) |
                     ((c & MASK_RED5) >> 9) | ((c & MASK_ALPHA1) >> 16);
         end
         MODE_XGRB32: begin
            result = (c & MASK_BYTE0) | ((c & MASK_BYTE1) << 8) |
                     ((c & MASK_BYTE2) >> 8);
         end
         default: begin
            result = c;
         end
      endcase
      return result;
   endfunction

endpackage

@@ rtl/core/lrast_front.sv @@
// Line setup front end: classifies requests and builds walker commands.
`timescale 1ns / 1ps

module lrast_front import lrast_pkg::*; #(
   parameter int  COORD_BITS = COORD_BITS_DEF,
   parameter type cmd_type   = logic
) (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   input  logic [COLOR_BITS-1:0] req_argb_color,
   input  logic [MODE_BITS-1:0]  color_mode,
   input  logic                  queue_full,
   output logic                  push,
   output cmd_type               cmd
);

   logic [COORD_BITS-1:0] adx, ady;
   logic [COORD_BITS-1:0] s_ax, s_ay, s_bx, s_by;
   logic [COORD_BITS-1:0] o_ax, o_ay, o_bx, o_by;
   logic                  steep, swap;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      adx = (req_x_start > req_x_end) ? req_x_start - req_x_end : req_x_end - req_x_start;
      ady = (req_y_start > req_y_end) ? req_y_start - req_y_end : req_y_end - req_y_start;
      steep = ady > adx;

      // Steep lines walk along y, so swap the axes.
      s_ax = steep ? req_y_start : req_x_start;
      s_ay = steep ? req_x_start : req_y_start;
      s_bx = steep ? req_y_end   : req_x_end;
      s_by = steep ? req_x_end   : req_y_end;

      // Order the endpoints so that the major coordinate rises.
      swap = s_ax > s_bx;
      o_ax = swap ? s_bx : s_ax;
      o_ay = swap ? s_by : s_ay;
      o_bx = swap ? s_ax : s_bx;
      o_by = swap ? s_ay : s_by;

      cmd             = '0;
      cmd.is_step     = (req_kind == KIND_STEP);
      cmd.major_pos   = o_ax;
      cmd.major_end   = o_bx;
      cmd.minor_pos   = o_ay;
      cmd.major_delta = o_bx - o_ax;
      cmd.minor_delta = (o_ay > o_by) ? o_ay - o_by : o_by - o_ay;
      cmd.minor_down  = !(o_ay < o_by);
      cmd.steep       = steep;
      cmd.color       = convert_color(color_mode, req_argb_color);
   end

endmodule

@@ rtl/core/lrast_queue.sv @@
// Short command queue between the setup front end and the walker.
`timescale 1ns / 1ps

module lrast_queue import lrast_pkg::*; #(
   parameter type cmd_type = logic
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;

   assign full       = (count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS + 1)'(push) - (PTR_BITS + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/lrast_walker.sv @@
// Bresenham walker: holds the line state and issues one pixel per step command.
`timescale 1ns / 1ps

module lrast_walker import lrast_pkg::*; #(
   parameter int  COORD_BITS = COORD_BITS_DEF,
   parameter type cmd_type   = logic,
   parameter type pixel_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  cmd_type   head_cmd,
   output logic      pop,
   output logic      pix_valid,
   input  logic      pix_ready,
   output pixel_type pix
);

   localparam int ERR_BITS = COORD_BITS + 2;

   logic [COORD_BITS-1:0]      major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0]      minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0]      major_end_ff, major_end_in;
   logic [COORD_BITS-1:0]      major_delta_ff, major_delta_in;
   logic [COORD_BITS-1:0]      minor_delta_ff, minor_delta_in;
   logic signed [ERR_BITS-1:0] error_ff, error_in;
   logic signed [ERR_BITS-1:0] error_sub;
   logic                       minor_down_ff, minor_down_in;
   logic                       steep_ff, steep_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;
   logic                       active_ff, active_in;
   logic                       load, advance, last;

   assign last      = (major_pos_ff == major_end_ff);
   assign pix_valid = head_valid && head_cmd.is_step && active_ff;
   assign load      = head_valid && !head_cmd.is_step;
   assign advance   = pix_valid && pix_ready;
   // A step with no line in progress is dropped without a pixel.
   assign pop       = load || advance || (head_valid && head_cmd.is_step && !active_ff);

   always_comb begin
      pix       = '0;
      pix.x     = steep_ff ? minor_pos_ff : major_pos_ff;
      pix.y     = steep_ff ? major_pos_ff : minor_pos_ff;
      pix.last  = last;
      pix.color = color_ff;
   end

   always_comb begin
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_end_in   = major_end_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      error_in       = error_ff;
      minor_down_in  = minor_down_ff;
      steep_in       = steep_ff;
      color_in       = color_ff;
      active_in      = active_ff;
      error_sub      = error_ff - $signed(ERR_BITS'(minor_delta_ff));

      if (load) begin
         major_pos_in   = head_cmd.major_pos;
         minor_pos_in   = head_cmd.minor_pos;
         major_end_in   = head_cmd.major_end;
         major_delta_in = head_cmd.major_delta;
         minor_delta_in = head_cmd.minor_delta;
         error_in       = $signed(ERR_BITS'(head_cmd.major_delta >> 1));
         minor_down_in  = head_cmd.minor_down;
         steep_in       = head_cmd.steep;
         color_in       = head_cmd.color;
         active_in      = 1'b1;
      end else if (advance) begin
         if (error_sub[ERR_BITS-1]) begin
            minor_pos_in = minor_down_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
            error_in     = error_sub + $signed(ERR_BITS'(major_delta_ff));
         end else begin
            error_in = error_sub;
         end
         if (last) begin
            active_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      major_end_ff   <= major_end_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      error_ff       <= error_in;
      minor_down_ff  <= minor_down_in;
      steep_ff       <= steep_in;
      color_ff       <= color_in;
   end

endmodule

@@ rtl/core/lrast_xform.sv @@
// Pixel transform pipeline: rotate and flip, clip flag, word offset, result register.
`timescale 1ns / 1ps

module lrast_xform import lrast_pkg::*; #(
   parameter int  COORD_BITS = COORD_BITS_DEF,
   parameter type pixel_type = logic
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   pix_valid,
   output logic                   pix_ready,
   input  pixel_type              pix,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COORD_BITS-1:0]  rsp_pix_x,
   output logic [COORD_BITS-1:0]  rsp_pix_y,
   output logic [OFFSET_BITS-1:0] rsp_pix_offset,
   output logic [COLOR_BITS-1:0]  rsp_pix_color,
   output logic                   rsp_off_screen,
   output logic                   rsp_last
);

   localparam int FLIP_BITS = (COORD_BITS > FB_DIM_BITS) ? COORD_BITS : FB_DIM_BITS;
   localparam int PROD_BITS = COORD_BITS + FB_DIM_BITS;
   localparam int SUM_BITS  = (PROD_BITS > OFFSET_BITS) ? PROD_BITS : OFFSET_BITS;

   // Stage 1: transformed coordinates.
   logic                  s1_valid_ff;
   logic [COORD_BITS-1:0] s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic                  s1_last_ff;
   logic [COLOR_BITS-1:0] s1_color_ff;
   logic [COORD_BITS-1:0] src_x, src_y;

   // Stage 2: row product and clip flag.
   logic                  s2_valid_ff;
   logic [COORD_BITS-1:0] s2_x_ff, s2_y_ff;
   logic [PROD_BITS-1:0]  s2_prod_ff, s2_prod_in;
   logic                  s2_off_ff, s2_off_in;
   logic                  s2_last_ff;
   logic [COLOR_BITS-1:0] s2_color_ff;

   // Stage 3: result register.
   logic                   s3_valid_ff;
   logic [OFFSET_BITS-1:0] s3_offset_in;
   logic [SUM_BITS-1:0]    sum;

   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign pix_ready = s1_ready;
   assign rsp_valid = s3_valid_ff;

   always_comb begin
      src_x = cfg.rotate_quarter ? pix.y : pix.x;
      src_y = cfg.rotate_quarter ? pix.x : pix.y;
      // Mirror across the buffer; an underflow wraps and is later clipped.
      s1_x_in = cfg.flip_horizontal
              ? COORD_BITS'(FLIP_BITS'(cfg.fb_width) - FLIP_BITS'(src_x) - FLIP_BITS'(1))
              : src_x;
      s1_y_in = cfg.flip_vertical
              ? COORD_BITS'(FLIP_BITS'(cfg.fb_height) - FLIP_BITS'(src_y) - FLIP_BITS'(1))
              : src_y;

      s2_prod_in = PROD_BITS'(s1_y_ff) * PROD_BITS'(cfg.fb_width);
      s2_off_in  = (FLIP_BITS'(s1_x_ff) >= FLIP_BITS'(cfg.fb_width)) ||
                   (FLIP_BITS'(s1_y_ff) >= FLIP_BITS'(cfg.fb_height));

      sum          = SUM_BITS'(s2_x_ff) + SUM_BITS'(s2_prod_ff);
      s3_offset_in = sum[OFFSET_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= pix_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_x_ff     <= s1_x_in;
         s1_y_ff     <= s1_y_in;
         s1_last_ff  <= pix.last;
         s1_color_ff <= pix.color;
      end
      if (s2_ready) begin
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         s2_prod_ff  <= s2_prod_in;
         s2_off_ff   <= s2_off_in;
         s2_last_ff  <= s1_last_ff;
         s2_color_ff <= s1_color_ff;
      end
      if (s3_ready) begin
         rsp_pix_x      <= s2_x_ff;
         rsp_pix_y      <= s2_y_ff;
         rsp_pix_offset <= s3_offset_in;
         rsp_pix_color  <= s2_color_ff;
         rsp_off_screen <= s2_off_ff;
         rsp_last       <= s2_last_ff;
      end
   end

endmodule

@@ rtl/core/line_rasterizer_unit.sv @@
// Top level of the Bresenham line rasterizer with its configuration registers.
`timescale 1ns / 1ps

// The line rasterizer turns line requests into frame buffer pixels. A start request
// (kind 0) loads two endpoints and a 32-bit ARGB color and produces no pixel; it
// abandons any line in progress. Each step request (kind 1) produces the next pixel of
// the current line, with last set on the final one; a step with no line in progress is
// consumed and produces nothing. Every pixel goes through the optional quarter turn and
// the horizontal and vertical mirrors, and carries its word offset x + y * fb_width
// (modulo 2^22). Pixels outside the buffer are flagged with off_screen, never dropped.
// The color is converted once, when the line starts, so a color mode change only
// affects later lines. The block accepts one request per clock and delivers one pixel
// per clock while the output side is not stalled. A step request passes through the
// command queue, then the mirror stage, the row multiply stage and the result register.
// The rate is set by the walker, which advances the Bresenham error term once per cycle
// while the transform pipeline takes its pixels. Configuration registers must be
// written only while no line request is in flight.

module line_rasterizer_unit import lrast_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [COORD_BITS-1:0]     req_x_start,
   input  logic [COORD_BITS-1:0]     req_y_start,
   input  logic [COORD_BITS-1:0]     req_x_end,
   input  logic [COORD_BITS-1:0]     req_y_end,
   input  logic [COLOR_BITS-1:0]     req_argb_color,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COORD_BITS-1:0]     rsp_pix_x,
   output logic [COORD_BITS-1:0]     rsp_pix_y,
   output logic [OFFSET_BITS-1:0]    rsp_pix_offset,
   output logic [COLOR_BITS-1:0]     rsp_pix_color,
   output logic                      rsp_off_screen,
   output logic                      rsp_last,

   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   // A command as it leaves the setup stage: endpoints already swapped for steep
   // lines and ordered so that the major coordinate rises.
   typedef struct packed {
      logic                  is_step;
      logic [COORD_BITS-1:0] major_pos;
      logic [COORD_BITS-1:0] major_end;
      logic [COORD_BITS-1:0] minor_pos;
      logic [COORD_BITS-1:0] major_delta;
      logic [COORD_BITS-1:0] minor_delta;
      logic                  minor_down;
      logic                  steep;
      logic [COLOR_BITS-1:0] color;
   } cmd_type;

   // A raw pixel from the walker, in buffer coordinates before the transform.
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
      logic [COLOR_BITS-1:0] color;
   } pixel_type;

   cfg_type   cfg_ff, cfg_in;
   cmd_type   push_cmd, head_cmd;
   pixel_type pix;
   logic      push, queue_full, pop, head_valid;
   logic      pix_valid, pix_ready;

   // Configuration registers. Writes to indexes beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FB_WIDTH:        cfg_in.fb_width        = csr_write_data;
            CSR_FB_HEIGHT:       cfg_in.fb_height       = csr_write_data;
            CSR_COLOR_MODE:      cfg_in.color_mode      = csr_write_data[MODE_BITS-1:0];
            CSR_ROTATE_QUARTER:  cfg_in.rotate_quarter  = csr_write_data[0];
            CSR_FLIP_HORIZONTAL: cfg_in.flip_horizontal = csr_write_data[0];
            CSR_FLIP_VERTICAL:   cfg_in.flip_vertical   = csr_write_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fb_width        <= FB_WIDTH_RESET;
         cfg_ff.fb_height       <= FB_HEIGHT_RESET;
         cfg_ff.color_mode      <= MODE_ARGB1555;
         cfg_ff.rotate_quarter  <= 1'b0;
         cfg_ff.flip_horizontal <= 1'b0;
         cfg_ff.flip_vertical   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies each request and, for a start, does the line setup.
   lrast_front #(
      .COORD_BITS (COORD_BITS),
      .cmd_type   (cmd_type)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_argb_color (req_argb_color),
      .color_mode     (cfg_ff.color_mode),
      .queue_full     (queue_full),
      .push           (push),
      .cmd            (push_cmd)
   );

   // The queue lets the front end keep taking requests while the pixel side stalls, until it is full.
   lrast_queue #(
      .cmd_type (cmd_type)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // The walker owns the line state and steps it once per pixel.
   lrast_walker #(
      .COORD_BITS (COORD_BITS),
      .cmd_type   (cmd_type),
      .pixel_type (pixel_type)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .pix_valid  (pix_valid),
      .pix_ready  (pix_ready),
      .pix        (pix)
   );

   // The transform pipeline rotates, mirrors, flags off-screen pixels and addresses each pixel.
   lrast_xform #(
      .COORD_BITS (COORD_BITS),
      .pixel_type (pixel_type)
   ) u_xform (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .pix_valid      (pix_valid),
      .pix_ready      (pix_ready),
      .pix            (pix),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pix_x      (rsp_pix_x),
      .rsp_pix_y      (rsp_pix_y),
      .rsp_pix_offset (rsp_pix_offset),
      .rsp_pix_color  (rsp_pix_color),
      .rsp_off_screen (rsp_off_screen),
      .rsp_last       (rsp_last)
   );

endmodule

@@ rtl/core/lrast_checker.sv @@
// Port-level assertions for the line rasterizer, bound to the top level.
`timescale 1ns / 1ps

module lrast_checker import lrast_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_kind,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [COORD_BITS-1:0]     rsp_pix_x,
   input logic [COORD_BITS-1:0]     rsp_pix_y,
   input logic [OFFSET_BITS-1:0]    rsp_pix_offset,
   input logic [COLOR_BITS-1:0]     rsp_pix_color,
   input logic                      rsp_off_screen,
   input logic                      rsp_last
);

   // Set once a start request has been taken since reset.
   logic seen_start_ff, seen_start_in;

   assign seen_start_in = seen_start_ff || (req_valid && req_ready && req_kind == KIND_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_start_ff <= 1'b0;
      end else begin
         seen_start_ff <= seen_start_in;
      end
   end

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel valid right after reset");

   a_pixel_needs_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_start_ff)
      else $error("pixel delivered before any line was started");

   a_row_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pix_y == '0 |-> rsp_pix_offset == OFFSET_BITS'(rsp_pix_x))
      else $error("offset on row zero differs from the column");

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("pixel withdrawn while stalled");

   a_rsp_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pix_offset) && $stable(rsp_pix_color) &&
                                  $stable(rsp_off_screen) && $stable(rsp_last))
      else $error("pixel changed while stalled");

endmodule

bind line_rasterizer_unit lrast_checker #(.COORD_BITS(COORD_BITS)) u_lrast_checker (.*);
